// ===== rtl/core/ffe_pkg.sv =====
`timescale 1ns / 1ps

package ffe_pkg;

  // Geometry defaults
  localparam int unsigned DefColumns = 84;
  localparam int unsigned DefRows    = 7;

  // Frame framing characters
  localparam logic [7:0] CharStx = 8'h02;
  localparam logic [7:0] CharEtx = 8'h03;

  // Display address after reset
  localparam logic [7:0] AddrReset = 8'h11;

  // Command codes
  typedef enum logic [1:0] {
    KIND_PIXEL  = 2'd0,
    KIND_CLEAR  = 2'd1,
    KIND_INVERT = 2'd2,
    KIND_EMIT   = 2'd3
  } kind_e;

  // Frame progress: next byte position and byte sum since STX
  typedef struct packed {
    logic [7:0] pos;
    logic [7:0] sum;
  } frame_t;

  // One frame byte
  typedef struct packed {
    logic [7:0] data;
    logic       last;
  } frame_out_t;

  // Uppercase ASCII hex of one nibble of v
  function automatic logic [7:0] hex_of(logic [7:0] v, logic high);
    logic [3:0] nib;
    nib = high ? v[7:4] : v[3:0];
    if (nib < 4'd10) begin
      return 8'h30 + {4'd0, nib};
    end
    return 8'h37 + {4'd0, nib};
  endfunction

endpackage

// ===== rtl/core/ffe_if.sv =====
`timescale 1ns / 1ps

// Command channel
interface ffe_cmd_if;
  logic               valid;
  logic               ready;
  logic        [1:0]  kind;
  logic signed [15:0] x;
  logic signed [15:0] y;
  logic        [15:0] color;

  modport source (output valid, kind, x, y, color, input ready);
  modport sink   (input valid, kind, x, y, color, output ready);
endinterface

// Frame byte channel
interface ffe_byte_if;
  logic       valid;
  logic       ready;
  logic [7:0] out_byte;
  logic       last_of_frame;

  modport source (output valid, out_byte, last_of_frame, input ready);
  modport sink   (input valid, out_byte, last_of_frame, output ready);
endinterface

// Address register write channel
interface ffe_cfg_if;
  logic       valid;
  logic       ready;
  logic [7:0] display_address;

  modport source (output valid, display_address, input ready);
  modport sink   (input valid, display_address, output ready);
endinterface

// ===== rtl/core/flipdot_frame_encoder.sv =====
`timescale 1ns / 1ps

// Pixel draw: column read, then write back; the next command waits until the write back is done.
// Emit: the column is read into the RAM read register, then the byte is loaded into
//   the output register; the block waits in EMIT while the previous byte is not taken.
// Clear all and invert all sweep the dots one column per cycle through the dot RAM's
//   single read and single write port.
// Reset: address 0x11, frame at STX, then a clearing pass over every column
//   during which no command transaction is taken.
module flipdot_frame_encoder import ffe_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns,
  parameter int unsigned ROWS    = DefRows
) (
  input  logic              clk_i,
  input  logic              rst_ni,
  ffe_cmd_if.sink           cmd_i,
  ffe_cfg_if.sink           cfg_i,
  ffe_byte_if.source        byte_o
);

  localparam int unsigned Aw = (COLUMNS > 1) ? $clog2(COLUMNS) : 1;
  localparam int unsigned Cw = $clog2(COLUMNS + 1);
  localparam int unsigned Yw = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam logic [7:0] DataEnd  = 8'(5 + 2 * COLUMNS);
  localparam logic [7:0] FrameLen = 8'(8 + 2 * COLUMNS);

  typedef enum logic [2:0] {
    ST_CLEAR,   // sweep writing the fill value
    ST_INVERT,  // pipelined read / invert / write sweep
    ST_IDLE,
    ST_PIXEL,   // write back the modified column
    ST_EMIT     // column data back, wait for output slot
  } state_e;

  state_e          state_q, state_d;
  logic [Cw-1:0]   cnt_q, cnt_d;
  logic [ROWS-1:0] fill_q, fill_d;
  logic [Aw-1:0]   addr_q, addr_d;
  logic [Yw-1:0]   bit_q, bit_d;
  logic            lit_q, lit_d;
  logic            inv_wr_q, inv_wr_d;
  logic [7:0]      disp_addr_q;
  frame_t          frame_q, frame_d;
  logic            out_valid_q, out_valid_d;
  frame_out_t      out_q, out_d;

  // RAM ports
  logic            ram_we, ram_re;
  logic [Aw-1:0]   ram_waddr, ram_raddr;
  logic [ROWS-1:0] ram_wdata, ram_rdata;

  logic            cmd_acc;
  logic            lit;
  logic            on_screen;
  logic [7:0]      col_off;
  logic [Aw-1:0]   emit_col;
  logic [ROWS-1:0] pix_mask;
  logic            out_free;
  frame_t          frame_nxt;
  frame_out_t      frame_res;

  ffe_ram #(
    .Width (ROWS),
    .Depth (COLUMNS)
  ) u_dots (
    .clk_i   (clk_i),
    .we_i    (ram_we),
    .waddr_i (ram_waddr),
    .wdata_i (ram_wdata),
    .re_i    (ram_re),
    .raddr_i (ram_raddr),
    .rdata_o (ram_rdata)
  );

  ffe_framer #(
    .COLUMNS (COLUMNS),
    .ROWS    (ROWS)
  ) u_framer (
    .frame_i (frame_q),
    .addr_i  (disp_addr_q),
    .col_i   (ram_rdata),
    .frame_o (frame_nxt),
    .res_o   (frame_res)
  );

  // Commands only in IDLE; the output register decouples the byte channel.
  assign cmd_i.ready = (state_q == ST_IDLE);
  assign cmd_acc     = cmd_i.valid && cmd_i.ready;
  assign cfg_i.ready = 1'b1;

  assign byte_o.valid         = out_valid_q;
  assign byte_o.out_byte      = out_q.data;
  assign byte_o.last_of_frame = out_q.last;

  assign lit       = |cmd_i.color[7:0];
  assign on_screen = !cmd_i.x[15] && !cmd_i.y[15]
                     && ($unsigned(cmd_i.x) < 16'(COLUMNS))
                     && ($unsigned(cmd_i.y) < 16'(ROWS));

  // Column behind the current frame position; only meaningful in the data part
  assign col_off  = (frame_q.pos - 8'd5) >> 1;
  assign emit_col = (frame_q.pos >= 8'd5 && frame_q.pos < DataEnd) ? col_off[Aw-1:0]
                                                                     : '0;
  assign pix_mask = ROWS'(1) << bit_q;
  assign out_free = !out_valid_q || byte_o.ready;

  always_comb begin
    state_d     = state_q;
    cnt_d       = cnt_q;
    fill_d      = fill_q;
    addr_d      = addr_q;
    bit_d       = bit_q;
    lit_d       = lit_q;
    inv_wr_d    = 1'b0;
    frame_d     = frame_q;
    out_d       = out_q;
    out_valid_d = out_valid_q && !byte_o.ready;
    ram_we      = 1'b0;
    ram_waddr   = '0;
    ram_wdata   = '0;
    ram_re      = 1'b0;
    ram_raddr   = '0;

    case (state_q)
      ST_CLEAR: begin
        ram_we    = 1'b1;
        ram_waddr = cnt_q[Aw-1:0];
        ram_wdata = fill_q;
        cnt_d     = cnt_q + Cw'(1);
        if (cnt_q == Cw'(COLUMNS - 1)) begin
          state_d = ST_IDLE;
        end
      end
      ST_INVERT: begin
        // read column n while column n-1 is written back inverted
        if (cnt_q != Cw'(COLUMNS)) begin
          ram_re    = 1'b1;
          ram_raddr = cnt_q[Aw-1:0];
          cnt_d     = cnt_q + Cw'(1);
          inv_wr_d  = 1'b1;
          addr_d    = cnt_q[Aw-1:0];
        end
        if (inv_wr_q) begin
          ram_we    = 1'b1;
          ram_waddr = addr_q;
          ram_wdata = ~ram_rdata;
        end
        if (cnt_q == Cw'(COLUMNS) && !inv_wr_q) begin
          state_d = ST_IDLE;
        end
      end
      ST_IDLE: begin
        if (cmd_acc) begin
          case (kind_e'(cmd_i.kind))
            KIND_PIXEL: begin
              // off-screen draws are consumed without effect
              if (on_screen) begin
                ram_re    = 1'b1;
                ram_raddr = cmd_i.x[Aw-1:0];
                addr_d    = cmd_i.x[Aw-1:0];
                bit_d     = cmd_i.y[Yw-1:0];
                lit_d     = lit;
                state_d   = ST_PIXEL;
              end
            end
            KIND_CLEAR: begin
              fill_d  = lit ? '1 : '0;
              cnt_d   = '0;
              state_d = ST_CLEAR;
            end
            KIND_INVERT: begin
              cnt_d   = '0;
              state_d = ST_INVERT;
            end
            KIND_EMIT: begin
              ram_re    = 1'b1;
              ram_raddr = emit_col;
              state_d   = ST_EMIT;
            end
            default: begin
              state_d = ST_IDLE;
            end
          endcase
        end
      end
      ST_PIXEL: begin
        ram_we    = 1'b1;
        ram_waddr = addr_q;
        ram_wdata = lit_q ? (ram_rdata | pix_mask) : (ram_rdata & ~pix_mask);
        state_d   = ST_IDLE;
      end
      ST_EMIT: begin
        // RAM read data holds while we wait for the output slot
        if (out_free) begin
          out_d       = frame_res;
          out_valid_d = 1'b1;
          frame_d     = frame_nxt;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_CLEAR;
      cnt_q       <= '0;
      fill_q      <= '0;
      inv_wr_q    <= 1'b0;
      disp_addr_q <= AddrReset;
      frame_q     <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      cnt_q       <= cnt_d;
      fill_q      <= fill_d;
      inv_wr_q    <= inv_wr_d;
      frame_q     <= frame_d;
      out_valid_q <= out_valid_d;
      if (cfg_i.valid && cfg_i.ready) begin
        disp_addr_q <= cfg_i.display_address;
      end
    end
  end

  // Payload registers
  always_ff @(posedge clk_i) begin
    addr_q <= addr_d;
    bit_q  <= bit_d;
    lit_q  <= lit_d;
    out_q  <= out_d;
  end

`ifndef SYNTH
  // Frame position never leaves the frame
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    frame_q.pos < FrameLen)
    else $error("frame position out of range");

  // The checksum's low character is the last thing loaded, so the frame wrapped
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_EMIT && out_free && frame_res.last) |=> (frame_q.pos == 8'd0))
    else $error("frame did not wrap after last byte");

  // RAM writes stay inside the column range
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    ram_we |-> (ram_waddr < Aw'(COLUMNS - 1) || ram_waddr == Aw'(COLUMNS - 1)))
    else $error("dot RAM write beyond last column");

  // A pixel read is always followed by its write back
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_PIXEL) |-> ram_we)
    else $error("pixel write back missing");
`endif

endmodule

// ===== rtl/core/ffe_ram.sv =====
`timescale 1ns / 1ps

// Simple dual-port RAM, one write and one registered read port
module ffe_ram #(
  parameter int unsigned Width = 8,
  parameter int unsigned Depth = 16,
  localparam int unsigned Aw = (Depth > 1) ? $clog2(Depth) : 1
) (
  input  logic             clk_i,
  input  logic             we_i,
  input  logic [Aw-1:0]    waddr_i,
  input  logic [Width-1:0] wdata_i,
  input  logic             re_i,
  input  logic [Aw-1:0]    raddr_i,
  output logic [Width-1:0] rdata_o
);

  logic [Width-1:0] mem_q [Depth];
  logic [Width-1:0] rdata_q;

  always_ff @(posedge clk_i) begin
    if (we_i) begin
      mem_q[waddr_i] <= wdata_i;
    end
    if (re_i) begin
      rdata_q <= mem_q[raddr_i];
    end
  end

  assign rdata_o = rdata_q;

endmodule

// ===== rtl/core/ffe_framer.sv =====
`timescale 1ns / 1ps

// Builds the frame byte at the current position and the next progress
module ffe_framer import ffe_pkg::*; #(
  parameter int unsigned COLUMNS = DefColumns,
  parameter int unsigned ROWS    = DefRows
) (
  input  frame_t          frame_i,
  input  logic [7:0]      addr_i,
  input  logic [ROWS-1:0] col_i,
  output frame_t          frame_o,
  output frame_out_t      res_o
);

  localparam logic [7:0] FrameLen = 8'(8 + 2 * COLUMNS);
  localparam logic [7:0] EtxPos   = 8'(5 + 2 * COLUMNS);
  localparam logic [7:0] CrcHiPos = 8'(6 + 2 * COLUMNS);
  localparam logic [7:0] ColCount = 8'(COLUMNS);

  logic [7:0] p;
  logic [7:0] crc;
  logic [7:0] col8;
  logic [7:0] data;
  logic       last;
  logic       summed;

  always_comb begin
    p      = (frame_i.pos >= FrameLen) ? 8'd0 : frame_i.pos;
    crc    = ~frame_i.sum + 8'd1;
    col8   = 8'(col_i);
    summed = 1'b1;
    last   = 1'b0;
    if (p == 8'd0) begin
      data   = CharStx;
      summed = 1'b0;
    end else if (p <= 8'd2) begin
      data = hex_of(addr_i, p == 8'd1);
    end else if (p <= 8'd4) begin
      data = hex_of(ColCount, p == 8'd3);
    end else if (p < EtxPos) begin
      // odd position carries the high nibble of the column
      data = hex_of(col8, p[0]);
    end else if (p == EtxPos) begin
      data = CharEtx;
    end else begin
      summed = 1'b0;
      data   = hex_of(crc, p == CrcHiPos);
      last   = (p != CrcHiPos);
    end

    if (p == 8'd0) begin
      frame_o.sum = 8'd0;
    end else if (summed) begin
      frame_o.sum = frame_i.sum + data;
    end else begin
      frame_o.sum = frame_i.sum;
    end
    frame_o.pos = last ? 8'd0 : p + 8'd1;
    res_o.data  = data;
    res_o.last  = last;
  end

endmodule

// ===== tb/tb_top.sv =====
`timescale 1ns / 1ps

// Testbench for flipdot_frame_encoder.
// A queue of pending commands feeds a clocked driver. A clocked monitor keeps
// its own copy of the dot store, frame position, checksum and address, and
// checks every frame byte against the oldest expected byte.
module tb_top;
  import ffe_pkg::*;

  localparam int NumCols      = DefColumns;
  localparam int NumRows      = DefRows;
  localparam int FrameLen     = 8 + 2 * NumCols;
  localparam int SettleCycles = NumCols + 16;  // longest no-result command, plus margin
  localparam int HoldCycles   = 300;           // long receiver back-off
  localparam int IdleLimit    = 4000;          // watchdog: cycles with no transaction

  typedef struct packed {
    kind_e              kind;
    logic signed [15:0] x;
    logic signed [15:0] y;
    logic        [15:0] color;
  } dot_cmd_t;

  logic clk;
  logic rst_n;

  ffe_cmd_if  cmd ();
  ffe_cfg_if  cfg ();
  ffe_byte_if byt ();

  flipdot_frame_encoder DUT (
    .clk_i  (clk),
    .rst_ni (rst_n),
    .cmd_i  (cmd),
    .cfg_i  (cfg),
    .byte_o (byt)
  );

  // Predicted sign state
  logic [NumRows-1:0] dot_store [NumCols];
  logic [7:0]         frame_pos;
  logic [7:0]         frame_sum;
  logic [7:0]         disp_addr;

  dot_cmd_t   pending_cmds [$];
  frame_out_t exp_bytes [$];

  int  errors;
  int  byte_count;
  int  idle_cycles;
  bit  cmd_taken;    // sampled at the rising edge, used by the driver at the falling edge
  bit  quiet;        // last phase: no idling on either side
  bit  hold_req;     // ask the receiver for one long back-off
  int  send_gap;
  int  recv_gap;
  int  hold_left;

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // Uppercase ASCII hex of one nibble
  function automatic logic [7:0] hex_char(logic [7:0] v, logic high);
    logic [3:0] nib;
    nib = high ? v[7:4] : v[3:0];
    if (nib > 4'd9) begin
      return 8'h41 + 8'(nib - 4'd10);  // 'A'
    end
    return 8'h30 + 8'(nib);            // '0'
  endfunction

  function automatic dot_cmd_t make_cmd(kind_e k, int xv, int yv, logic [15:0] c);
    dot_cmd_t d;
    d.kind  = k;
    d.x     = 16'(xv);
    d.y     = 16'(yv);
    d.color = c;
    return d;
  endfunction

  // Apply one accepted command to the predicted state; emit queues its byte.
  task automatic predict_command(dot_cmd_t c);
    int         xi;
    int         yi;
    int         p;
    int         k;
    logic [7:0] b;
    logic [7:0] col;
    logic [7:0] crc;
    logic       lit;
    logic       last;
    logic       summed;
    frame_out_t e;
    lit = (c.color[7:0] != 8'h00);
    case (c.kind)
      KIND_PIXEL: begin
        xi = $signed(c.x);
        yi = $signed(c.y);
        // off-screen draws are dropped
        if (xi >= 0 && yi >= 0 && xi < NumCols && yi < NumRows) begin
          dot_store[xi][yi] = lit;
        end
      end
      KIND_CLEAR: begin
        foreach (dot_store[i]) dot_store[i] = lit ? '1 : '0;
      end
      KIND_INVERT: begin
        foreach (dot_store[i]) dot_store[i] = ~dot_store[i];
      end
      default: begin
        p = frame_pos;
        if (p >= FrameLen) p = 0;
        last   = 1'b0;
        summed = 1'b1;
        if (p == 0) begin
          b         = CharStx;
          frame_sum = 8'h00;
          summed    = 1'b0;
        end else if (p <= 2) begin
          b = hex_char(disp_addr, p == 1);
        end else if (p <= 4) begin
          b = hex_char(8'(NumCols), p == 3);
        end else if (p < 5 + 2 * NumCols) begin
          // column bytes: high nibble first, built from the dots as they are now
          k   = p - 5;
          col = '0;
          col[NumRows-1:0] = dot_store[k / 2];
          b   = hex_char(col, (k % 2) == 0);
        end else if (p == 5 + 2 * NumCols) begin
          b = CharEtx;
        end else begin
          // checksum: negated byte sum since STX, ETX included
          crc    = 8'h00 - frame_sum;
          summed = 1'b0;
          b      = hex_char(crc, p == 6 + 2 * NumCols);
          last   = (p != 6 + 2 * NumCols);
        end
        if (summed) frame_sum = frame_sum + b;
        frame_pos = last ? 8'h00 : 8'(p + 1);
        e.data = b;
        e.last = last;
        exp_bytes.push_back(e);
      end
    endcase
  endtask

  task automatic note_error(string msg);
    errors++;
    if (errors <= 10) $display("mismatch: %s", msg);
  endtask

  // Monitor and watchdog: everything here samples at the rising edge.
  always @(posedge clk) begin
    frame_out_t want;
    bit         moved;
    moved = 1'b0;
    if (rst_n) begin
      if (byt.valid && byt.ready) begin
        moved = 1'b1;
        if (exp_bytes.size() == 0) begin
          note_error($sformatf("byte %0d unexpected: got %h last %b",
                               byte_count, byt.out_byte, byt.last_of_frame));
        end else begin
          want = exp_bytes.pop_front();
          if (byt.out_byte !== want.data || byt.last_of_frame !== want.last) begin
            note_error($sformatf("byte %0d: expected %h last %b, got %h last %b",
                                 byte_count, want.data, want.last,
                                 byt.out_byte, byt.last_of_frame));
          end
        end
        byte_count++;
      end
      if (cfg.valid && cfg.ready) begin
        moved     = 1'b1;
        disp_addr = cfg.display_address;
      end
      cmd_taken = cmd.valid && cmd.ready;
      if (cmd_taken) begin
        moved = 1'b1;
        predict_command(dot_cmd_t'({cmd.kind, cmd.x, cmd.y, cmd.color}));
      end
    end
    idle_cycles = moved ? 0 : idle_cycles + 1;
    if (idle_cycles >= IdleLimit) begin
      $display("CHECK FAILED");
      $finish;
    end
  end

  // Command driver: next transaction from the queue, with random idle bursts.
  always @(negedge clk) begin
    dot_cmd_t c;
    if (rst_n && (!cmd.valid || cmd_taken)) begin
      if (send_gap != 0) begin
        send_gap--;
        cmd.valid <= 1'b0;
      end else if (!quiet && pending_cmds.size() != 0 && $urandom_range(0, 9) == 0) begin
        send_gap = $urandom_range(0, 6);  // idle burst of random length
        cmd.valid <= 1'b0;
      end else if (pending_cmds.size() != 0) begin
        c = pending_cmds.pop_front();
        cmd.valid <= 1'b1;
        cmd.kind  <= c.kind;
        cmd.x     <= c.x;
        cmd.y     <= c.y;
        cmd.color <= c.color;
      end else begin
        cmd.valid <= 1'b0;
      end
    end
  end

  // Byte receiver: random stalls, plus one long back-off on request.
  always @(negedge clk) begin
    if (rst_n) begin
      if (hold_left != 0) begin
        hold_left--;
        byt.ready <= 1'b0;
      end else if (hold_req) begin
        hold_req  = 1'b0;
        hold_left = HoldCycles - 1;
        byt.ready <= 1'b0;
      end else if (recv_gap != 0) begin
        recv_gap--;
        byt.ready <= 1'b0;
      end else if (!quiet && $urandom_range(0, 9) == 0) begin
        recv_gap = $urandom_range(0, 6);
        byt.ready <= 1'b0;
      end else begin
        byt.ready <= 1'b1;
      end
    end
  end

  task automatic write_address(logic [7:0] a);
    @(negedge clk);
    cfg.valid           <= 1'b1;
    cfg.display_address <= a;
    do @(posedge clk); while (!cfg.ready);
    @(negedge clk);
    cfg.valid <= 1'b0;
  endtask

  // Wait until every command is taken and every byte has come out, then let
  // a trailing clear or invert finish.
  task automatic wait_drained();
    do @(posedge clk); while (pending_cmds.size() != 0 || cmd.valid || exp_bytes.size() != 0);
    repeat (SettleCycles) @(negedge clk);
  endtask

  // Random traffic: runs of frame bytes, runs of pixels, occasional clear/invert.
  task automatic queue_random(int n);
    int       added;
    int       run;
    int       r;
    bit       counts;
    dot_cmd_t c;
    added = 0;
    while (added < n) begin
      r   = $urandom_range(0, 99);
      run = (r < 50) ? $urandom_range(1, 40) : (r < 85) ? $urandom_range(1, 12) : 1;
      repeat (run) begin
        c.x     = 16'($urandom);
        c.y     = 16'($urandom);
        c.color = 16'($urandom);
        if ($urandom_range(0, 2) == 0) c.color[7:0] = 8'h00;
        counts = 1'b1;
        if (r < 50) begin
          c.kind = KIND_EMIT;
        end else if (r < 85) begin
          c.kind = KIND_PIXEL;
          if ($urandom_range(0, 7) != 0) begin
            c.x = 16'($urandom_range(0, NumCols - 1));
            c.y = 16'($urandom_range(0, NumRows - 1));
          end else begin
            // full-range coordinates, sometimes just past the right/bottom edge
            if ($urandom_range(0, 3) == 0) c.x = 16'(NumCols);
            if ($urandom_range(0, 3) == 0) c.y = 16'(NumRows);
            counts = 1'b0;
          end
        end else if (r < 93) begin
          c.kind = KIND_CLEAR;
        end else begin
          c.kind = KIND_INVERT;
        end
        pending_cmds.push_back(c);
        if (counts) added++;
      end
    end
  endtask

  initial begin
    rst_n               = 1'b0;
    cmd.valid           = 1'b0;
    cmd.kind            = KIND_PIXEL;
    cmd.x               = '0;
    cmd.y               = '0;
    cmd.color           = '0;
    cfg.valid           = 1'b0;
    cfg.display_address = '0;
    byt.ready           = 1'b0;
    foreach (dot_store[i]) dot_store[i] = '0;
    frame_pos   = '0;
    frame_sum   = '0;
    disp_addr   = AddrReset;
    errors      = 0;
    byte_count  = 0;
    idle_cycles = 0;
    cmd_taken   = 1'b0;
    quiet       = 1'b0;
    hold_req    = 1'b0;
    send_gap    = 0;
    recv_gap    = 0;
    hold_left   = 0;

    repeat (8) @(negedge clk);
    rst_n <= 1'b1;

    // Directed: field extremes, every command, off-screen draws, unlit colors
    write_address(8'h00);
    pending_cmds.push_back(make_cmd(KIND_PIXEL, 0, 0, 16'h0001));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, NumCols - 1, NumRows - 1, 16'h0080));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, NumCols, 0, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, -1, 1, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, 2, NumRows, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, 3, -1, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, -32768, 32767, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, 32767, -32768, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, 0, 0, 16'hFF00));  // low byte zero: unlit
    pending_cmds.push_back(make_cmd(KIND_EMIT, 0, 0, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_EMIT, -1, -1, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_EMIT, 0, 0, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_EMIT, 0, 0, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_EMIT, 0, 0, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_EMIT, 0, 0, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_CLEAR, 0, 0, 16'h00FF));
    pending_cmds.push_back(make_cmd(KIND_EMIT, 0, 0, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_PIXEL, 5, 3, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_INVERT, -1, -1, 16'hFFFF));
    pending_cmds.push_back(make_cmd(KIND_EMIT, 0, 0, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_CLEAR, 0, 0, 16'hFF00));  // clears to unlit
    pending_cmds.push_back(make_cmd(KIND_INVERT, 0, 0, 16'h0000));
    pending_cmds.push_back(make_cmd(KIND_EMIT, 0, 0, 16'h0000));
    wait_drained();

    // Receiver backs off for a long stretch while frame bytes keep coming
    write_address(8'hFF);
    hold_req = 1'b1;
    repeat (24) pending_cmds.push_back(make_cmd(KIND_EMIT, 0, 0, 16'h0000));
    queue_random(120);
    wait_drained();

    write_address(8'($urandom));
    queue_random(140);
    wait_drained();

    write_address(8'h5A);
    queue_random(140);
    wait_drained();

    write_address(8'($urandom));
    queue_random(140);
    wait_drained();

    // Closing stretch at full rate
    quiet = 1'b1;
    write_address(8'($urandom));
    queue_random(140);
    wait_drained();

    if (errors == 0) begin
      $display("CHECK OK");
    end else begin
      $display("CHECK FAILED");
    end
    $finish;
  end

endmodule
